### design/cist_pkg.sv
// Package for the CAN identifier statistics table.
// Holds the item, result and table entry types, operation and status codes.
// Used by the controller, the datapath and the top level; depends on nothing.
package cist_pkg;

  // Number of table entries and the widths that follow from it.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned FILL_W        = IDX_W + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

  // Fixed field widths of the channels.
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned ID_W      = 29;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned FRAMES_W  = 32;
  localparam int unsigned MUX_W     = 16;
  localparam int unsigned NUM_BYTES = 8;

  // Frame length saturation limit and mux byte limit.
  localparam logic [LEN_W-1:0] MAX_LEN   = 4'd8;
  localparam logic [7:0]       MUX_LIMIT = 8'd16;

  // Operation codes.
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_READ_OK  = 3'd3;
  localparam logic [2:0] ST_READ_OOR = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // One input transaction.
  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   can_id;
    logic              frame_extended;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] frame_data;
    logic [TIME_W-1:0] time_us;
    logic [SLOT_W-1:0] entry_index;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]          status;
    logic [SLOT_W-1:0]   slot_index;
    logic [LEVEL_W-1:0]  fill_level;
    logic [ID_W-1:0]     read_id;
    logic                read_extended;
    logic [LEN_W-1:0]    read_length;
    logic [DATA_W-1:0]   read_payload;
    logic [FRAMES_W-1:0] read_frame_count;
    logic [MUX_W-1:0]    read_mux_mask;
    logic [TIME_W-1:0]   read_first_time;
    logic [TIME_W-1:0]   read_last_time;
  } result_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic                ext;
    logic [ID_W-1:0]     id;
    logic [LEN_W-1:0]    length;
    logic [DATA_W-1:0]   payload;
    logic [FRAMES_W-1:0] frames;
    logic [MUX_W-1:0]    mux_mask;
    logic [TIME_W-1:0]   first_time;
    logic [TIME_W-1:0]   last_time;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic rd;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_end;
  } dp_sts_t;

endpackage

### design/cist_ram.sv
// Generic single-port RAM with a registered read port.
// Self-contained; used for the entry table of the statistics block.
module cist_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port share one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/cist_dp.sv
// Datapath of the CAN identifier statistics table: item register, scan
// counter, entry memory, entry update logic and result register.
// Depends on cist_pkg and cist_ram.
module cist_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cist_pkg::item_t   item_i,
  input  cist_pkg::dp_cmd_t cmd_i,
  output cist_pkg::dp_sts_t sts_o,
  output logic              done_o,
  output cist_pkg::result_t res_o
);

  cist_pkg::item_t   item_q;
  cist_pkg::entry_t  ent_q;
  cist_pkg::entry_t  rdata_e;
  cist_pkg::entry_t  base_e;
  cist_pkg::entry_t  new_e;
  cist_pkg::result_t res_d, res_q;

  logic [cist_pkg::FILL_W-1:0]  fill_d, fill_q;
  logic [cist_pkg::FILL_W-1:0]  scan_addr_q;
  logic [cist_pkg::IDX_W-1:0]   cmp_idx_q;
  logic [cist_pkg::IDX_W-1:0]   slot_q;
  logic                         cmp_vld_q;
  logic                         found_q;
  logic                         done_q;
  logic                         scan_more;
  logic                         hit;
  logic                         is_full;
  logic                         rd_in_range;
  logic [cist_pkg::LEN_W-1:0]   len_sat;
  logic [cist_pkg::DATA_W-1:0]  byte_mask;

  logic                         ram_we, ram_re;
  logic [cist_pkg::IDX_W-1:0]   ram_addr;
  logic [cist_pkg::ENTRY_W-1:0] ram_rdata;

  // Entry table memory.
  cist_ram #(
    .WIDTH (cist_pkg::ENTRY_W),
    .DEPTH (cist_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (new_e),
    .rdata_o (ram_rdata)
  );

  assign rdata_e = cist_pkg::entry_t'(ram_rdata);

  // Scan compare: the registered read data belongs to cmp_idx_q.
  assign scan_more = (scan_addr_q < fill_q);
  assign hit = cmd_i.scan && cmp_vld_q && (rdata_e.ext == item_q.frame_extended) &&
               (rdata_e.id == item_q.can_id);
  assign sts_o.hit      = hit;
  assign sts_o.scan_end = !scan_more;

  assign is_full     = (fill_q >= cist_pkg::FILL_MAX);
  assign rd_in_range = (cist_pkg::FILL_W'(item_q.entry_index) < fill_q);

  // Entry update: saturate length, merge the leading bytes, set mux bit, count the frame and stamp the last time.
  always_comb begin
    len_sat = (item_q.frame_length > cist_pkg::MAX_LEN) ? cist_pkg::MAX_LEN
                                                        : item_q.frame_length;
    for (int b = 0; b < cist_pkg::NUM_BYTES; b++) begin
      byte_mask[8*b +: 8] = {8{cist_pkg::LEN_W'(b) < len_sat}};
    end

    if (found_q) begin
      base_e = ent_q;
    end else begin
      base_e            = '0;
      base_e.ext        = item_q.frame_extended;
      base_e.id         = item_q.can_id;
      base_e.first_time = item_q.time_us;
      base_e.last_time  = item_q.time_us;
    end

    new_e           = base_e;
    new_e.length    = len_sat;
    new_e.payload   = (base_e.payload & ~byte_mask) | (item_q.frame_data & byte_mask);
    if ((len_sat != '0) && (item_q.frame_data[7:0] < cist_pkg::MUX_LIMIT)) begin
      new_e.mux_mask = base_e.mux_mask |
                       (cist_pkg::MUX_W'(1) << item_q.frame_data[3:0]);
    end
    new_e.frames    = base_e.frames + cist_pkg::FRAMES_W'(1);
    new_e.last_time = item_q.time_us;
  end

  // Memory port selection between scan, read and write back.
  always_comb begin
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = scan_addr_q[cist_pkg::IDX_W-1:0];
    if (cmd_i.scan) begin
      ram_re = scan_more;
    end else if (cmd_i.rd) begin
      ram_re   = 1'b1;
      ram_addr = cist_pkg::IDX_W'(item_q.entry_index);
    end else if (cmd_i.finish && (item_q.operation == cist_pkg::OP_RECORD)) begin
      if (found_q) begin
        ram_we   = 1'b1;
        ram_addr = slot_q;
      end else if (!is_full) begin
        ram_we   = 1'b1;
        ram_addr = fill_q[cist_pkg::IDX_W-1:0];
      end
    end
  end

  // Result formation and the next fill level.
  always_comb begin
    res_d  = '0;
    fill_d = fill_q;
    res_d.status     = cist_pkg::ST_READ_OOR;
    res_d.fill_level = cist_pkg::LEVEL_W'(fill_q);
    unique case (item_q.operation)
      cist_pkg::OP_RECORD: begin
        if (found_q || !is_full) begin
          if (found_q) begin
            res_d.status     = cist_pkg::ST_UPDATED;
            res_d.slot_index = cist_pkg::SLOT_W'(slot_q);
          end else begin
            fill_d           = fill_q + cist_pkg::FILL_W'(1);
            res_d.status     = cist_pkg::ST_INSERTED;
            res_d.slot_index = cist_pkg::SLOT_W'(fill_q[cist_pkg::IDX_W-1:0]);
            res_d.fill_level = cist_pkg::LEVEL_W'(fill_d);
          end
          res_d.read_id          = new_e.id;
          res_d.read_extended    = new_e.ext;
          res_d.read_length      = new_e.length;
          res_d.read_payload     = new_e.payload;
          res_d.read_frame_count = new_e.frames;
          res_d.read_mux_mask    = new_e.mux_mask;
          res_d.read_first_time  = new_e.first_time;
          res_d.read_last_time   = new_e.last_time;
        end else begin
          res_d.status = cist_pkg::ST_DROPPED;
        end
      end
      cist_pkg::OP_READ: begin
        if (rd_in_range) begin
          res_d.status           = cist_pkg::ST_READ_OK;
          res_d.slot_index       = item_q.entry_index;
          res_d.read_id          = rdata_e.id;
          res_d.read_extended    = rdata_e.ext;
          res_d.read_length      = rdata_e.length;
          res_d.read_payload     = rdata_e.payload;
          res_d.read_frame_count = rdata_e.frames;
          res_d.read_mux_mask    = rdata_e.mux_mask;
          res_d.read_first_time  = rdata_e.first_time;
          res_d.read_last_time   = rdata_e.last_time;
        end
      end
      cist_pkg::OP_CLEAR: begin
        fill_d           = '0;
        res_d.status     = cist_pkg::ST_CLEARED;
        res_d.fill_level = '0;
      end
      default: begin
        // The unused operation answers like an out-of-range read.
        res_d.status = cist_pkg::ST_READ_OOR;
      end
    endcase
  end

  // Control registers: scan state, hit flag, fill level and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      scan_addr_q <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        scan_addr_q <= '0;
        cmp_vld_q   <= 1'b0;
        found_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= scan_more;
        if (scan_more) begin
          scan_addr_q <= scan_addr_q + cist_pkg::FILL_W'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        fill_q <= fill_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= scan_addr_q[cist_pkg::IDX_W-1:0];
      if (hit) begin
        ent_q  <= rdata_e;
        slot_q <= cmp_idx_q;
      end
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### design/cist_ctrl.sv
// Controller of the CAN identifier statistics table: sequences load, table
// scan, entry read and finish steps of one transaction.
// Depends on cist_pkg.
module cist_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        op_i,
  input  cist_pkg::dp_sts_t sts_i,
  output logic              busy_o,
  output cist_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_d, state_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (op_i == cist_pkg::OP_RECORD) begin
            state_d = S_SCAN;
          end else if (op_i == cist_pkg::OP_READ) begin
            state_d = S_READ;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.scan_end) begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### design/can_id_statistics_table.sv
// Top level of the CAN identifier statistics table.
// Joins the controller and the datapath; depends on cist_pkg, cist_ctrl,
// cist_dp and cist_ram.
//
// Usage: a transaction is accepted at a rising edge where start_i is high
// and busy_o is low; item_i carries the operation (record, read, clear).
// Each transaction gives exactly one result on res_o, valid for the single
// cycle in which done_o is high. The receiver cannot stall the result, so
// it must take res_o whenever done_o is set.
// Steps from the accepting edge to the result:
//   record: a table scan up to the fill level that ends at the first hit
//           or after the last filled entry, then the finish step. The scan
//           reads one entry per cycle through the single memory port.
//   read:   one memory read, then the finish step.
//   clear and unused operation: the finish step only.
// busy_o is high until the result is placed; a new transaction may start in
// the cycle that shows the result.
// Reset clears the fill level and the controller; the table memory is not
// cleared, and entries at or above the fill level are never reported.
module can_id_statistics_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cist_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              done_o,
  output cist_pkg::result_t res_o
);

  cist_pkg::dp_cmd_t cmd;
  cist_pkg::dp_sts_t sts;

  // Controller sequencing each transaction.
  cist_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (item_i.operation),
    .sts_i   (sts),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Datapath with the entry table.
  cist_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
